[hdl/brpe_pkg.sv]
package brpe_pkg;

    localparam int BYTE_BITS = 8;
    localparam int POS_W     = 4;   // holds 0..BYTE_BITS
    localparam int PER_W     = 16;
    localparam int DUR_W     = 32;
    localparam int PROD_W    = POS_W + PER_W;

    localparam logic [PER_W-1:0] PER_RESET = 16'h0001;
    localparam logic [POS_W-1:0] NBITS_MAX = 4'd8;

    // what the merge stage decides for the current step of an item
    typedef struct packed {
        logic             emit;       // a run goes out this step
        logic             last;       // run is the frame-end flush
        logic             done;       // item's bits are used up
        logic [DUR_W-1:0] dur;        // duration of the run so far
        logic [POS_W-1:0] pos_next;   // bit position of the next step
        logic             level_next;
        logic [DUR_W-1:0] dur_next;
    } merge_res_t;

endpackage

[hdl/brpe_lane.sv]
module brpe_lane #(
    parameter int LaneIdx = 0
) (
    input  logic                     data_bit,
    input  logic                     ref_level,
    input  logic [brpe_pkg::POS_W-1:0] pos,
    input  logic [brpe_pkg::POS_W-1:0] nbits,
    output logic                     mismatch
);
    import brpe_pkg::*;

    localparam logic [POS_W-1:0] MyPos = POS_W'(LaneIdx);

    // bit still ahead of the scan point, inside the frame, and breaking the run
    assign mismatch = (MyPos >= pos) && (MyPos < nbits) && (data_bit != ref_level);

endmodule

[hdl/brpe_merge.sv]
module brpe_merge (
    input  logic [brpe_pkg::BYTE_BITS-1:0] mismatch,
    input  logic [brpe_pkg::POS_W-1:0]     pos,
    input  logic [brpe_pkg::POS_W-1:0]     nbits,
    input  logic                           frame_end,
    input  logic                           cur_level,
    input  logic [brpe_pkg::DUR_W-1:0]     cur_dur,
    input  logic [brpe_pkg::PER_W-1:0]     period,
    output brpe_pkg::merge_res_t           res
);
    import brpe_pkg::*;

    logic              found;
    logic [POS_W-1:0]  first_pos;
    logic [POS_W-1:0]  end_pos;
    logic [POS_W-1:0]  count;
    logic [PROD_W-1:0] prod;
    logic [DUR_W:0]    sum;
    logic [DUR_W-1:0]  dur_sat;

    // first breaking lane, lowest index wins
    always_comb
    begin
        found     = 1'b0;
        first_pos = '0;
        for (int i = BYTE_BITS - 1; i >= 0; i--)
        begin
            if (mismatch[i])
            begin
                found     = 1'b1;
                first_pos = POS_W'(i);
            end
        end
    end

    assign end_pos = found ? first_pos : nbits;
    assign count   = end_pos - pos;
    assign prod    = PROD_W'(count) * PROD_W'(period);
    assign sum     = {1'b0, cur_dur} + (DUR_W + 1)'(prod);
    assign dur_sat = sum[DUR_W] ? {DUR_W{1'b1}} : sum[DUR_W-1:0];

    always_comb
    begin
        res.dur        = dur_sat;
        res.emit       = (found || frame_end) && (dur_sat != '0);
        res.last       = !found;
        res.done       = !found;
        res.pos_next   = found ? first_pos : '0;
        res.level_next = found ? !cur_level : (cur_level && !frame_end);
        res.dur_next   = (found || frame_end) ? '0 : dur_sat;
    end

endmodule

[hdl/bit_run_to_pulse_encoder.sv]
// bit run to pulse encoder: takes frame bytes MSB first (bits_valid leading bits
// of each, above 8 taken as 8) and returns one beat per run of equal bits with
// its level and duration = run length * element_period, saturating at all ones;
// an element_period of 0 acts as 1. a run goes out when the level changes, and
// on a frame_end beat the open run is flushed with run_last set and the run
// state returns to level 0 with no open run. each byte sits in an item register
// while eight bit lanes compare its bits against the open run level and a merge
// stage picks the first break; one step per cycle, unless stalled as said below,
// either closes a run or folds the rest of the byte into the open run, so a byte
// takes one step per level change in it plus one, with the duration multiply-add
// of the merge stage done within that step. the next byte is taken in the cycle
// the current one finishes. a finished run waits in the output register while
// the lanes go on; only a step that closes another run stalls until the output
// register drains. cfg_data is taken at any time (cfg_ready is always high) but
// should only be written while idle.
module bit_run_to_pulse_encoder (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [brpe_pkg::PER_W-1:0]     cfg_data,
    // byte input
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic [3:0]                     bits_valid,
    input  logic                           frame_end,
    // run output
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [31:0]                    run_duration,
    output logic                           run_level,
    output logic                           run_last
);
    import brpe_pkg::*;

    // config
    logic [PER_W-1:0]     period_reg;
    logic [PER_W-1:0]     period_eff;

    // item register
    logic                 item_valid_reg;
    logic [BYTE_BITS-1:0] byte_reg;
    logic [POS_W-1:0]     nbits_reg;
    logic                 fend_reg;
    logic [POS_W-1:0]     pos_reg;
    logic [POS_W-1:0]     nbits_clamped;

    // open run
    logic                 cur_level_reg;
    logic [DUR_W-1:0]     cur_dur_reg;

    // output register
    logic                 out_valid_reg;
    logic [DUR_W-1:0]     out_dur_reg;
    logic                 out_level_reg;
    logic                 out_last_reg;

    logic [BYTE_BITS-1:0] mismatch;
    merge_res_t           res;
    logic                 out_free;
    logic                 step;
    logic                 in_beat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            period_reg <= cfg_data;
        end
    end

    // zero period behaves as one
    assign period_eff = (period_reg == '0) ? PER_RESET : period_reg;

    // lanes: one per bit position, MSB is position 0
    for (genvar i = 0; i < BYTE_BITS; i++)
    begin : g_lane
        brpe_lane #(
            .LaneIdx (i)
        ) u_lane (
            .data_bit  (byte_reg[BYTE_BITS-1-i]),
            .ref_level (cur_level_reg),
            .pos       (pos_reg),
            .nbits     (nbits_reg),
            .mismatch  (mismatch[i])
        );
    end

    brpe_merge u_merge (
        .mismatch  (mismatch),
        .pos       (pos_reg),
        .nbits     (nbits_reg),
        .frame_end (fend_reg),
        .cur_level (cur_level_reg),
        .cur_dur   (cur_dur_reg),
        .period    (period_eff),
        .res       (res)
    );

    // a step goes ahead unless it has a run to send and the output is still full
    assign out_free = !out_valid_reg || out_ready;
    assign step     = item_valid_reg && (!res.emit || out_free);
    assign in_ready = !item_valid_reg || (step && res.done);
    assign in_beat  = in_valid && in_ready;

    assign nbits_clamped = (bits_valid > NBITS_MAX) ? NBITS_MAX : bits_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            pos_reg        <= '0;
            cur_level_reg  <= 1'b0;
            cur_dur_reg    <= '0;
        end
        else
        begin
            if (in_beat)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (step && res.done)
            begin
                item_valid_reg <= 1'b0;
            end
            if (step)
            begin
                pos_reg       <= res.pos_next;
                cur_level_reg <= res.level_next;
                cur_dur_reg   <= res.dur_next;
            end
        end
    end

    // item payload
    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            byte_reg  <= data_byte;
            nbits_reg <= nbits_clamped;
            fend_reg  <= frame_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step && res.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && res.emit)
        begin
            out_dur_reg   <= res.dur;
            out_level_reg <= cur_level_reg;
            out_last_reg  <= res.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign run_duration = out_dur_reg;
    assign run_level    = out_level_reg;
    assign run_last     = out_last_reg;

    // scan point never passes the end of the valid bits
    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (pos_reg <= nbits_reg))
        else $error("scan position beyond valid bits");

    // an idle item register always restarts at position zero
    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !item_valid_reg |-> (pos_reg == '0))
        else $error("scan position not cleared between bytes");

    // no empty run ever goes out
    a_no_empty_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_dur_reg != '0))
        else $error("zero duration run on output");

    // finishing a frame-end byte leaves the run state cleared
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (step && res.done && fend_reg) |=> (cur_dur_reg == '0) && !cur_level_reg)
        else $error("run state not cleared after frame end");

endmodule

[dv/tb_bit_run_to_pulse_encoder.sv]
module tb_bit_run_to_pulse_encoder;

    timeunit 1ns;
    timeprecision 1ps;

    import brpe_pkg::*;

    // cycles the block may still be busy after the last expected run
    localparam int unsigned DRAIN_CYCLES  = 16;
    // receiver hold-off length for the fill-up test
    localparam int unsigned HOLD_CYCLES   = 300;
    // cycles with no beat on any channel before the run is abandoned
    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned REPORT_LIMIT  = 10;
    localparam int unsigned PHASE_ITEMS   = 110;

    // one expected run as it should leave the block
    typedef struct packed {
        logic [DUR_W-1:0] dur;
        logic             level;
        logic             last;
    } run_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [PER_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [7:0]           data_byte;
    logic [3:0]           bits_valid;
    logic                 frame_end;
    logic                 out_valid;
    logic                 out_ready;
    logic [31:0]          run_duration;
    logic                 run_level;
    logic                 run_last;

    // run encoder state mirrored on the testbench side
    logic [PER_W-1:0]     period_cfg = PER_RESET;
    logic                 open_level = 1'b0;
    logic [DUR_W-1:0]     open_dur   = '0;
    run_t                 expected_runs[$];

    // beats seen at the falling edge, valid for the rising edge that follows
    bit                   in_beat;
    bit                   out_beat;
    bit                   cfg_beat;

    int unsigned          mismatches = 0;
    int unsigned          quiet_cycles = 0;
    int unsigned          send_idle_pct = 0;
    int unsigned          recv_idle_pct = 0;

    // toggle pair that asks the receiver for one long hold-off
    bit                   hold_req  = 1'b0;
    bit                   hold_seen = 1'b0;

    bit_run_to_pulse_encoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .bits_valid   (bits_valid),
        .frame_end    (frame_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .run_duration (run_duration),
        .run_level    (run_level),
        .run_last     (run_last)
    );

    always #1 clk = ~clk;

    // walk the valid bits of one accepted byte, msb first, and queue every
    // run that closes on a level change plus the flush at frame end
    task automatic predict_runs(input logic [7:0] b, input logic [3:0] nv, input logic fe);
        int unsigned per;
        int unsigned nbits;
        int unsigned i;
        logic        bit_val;
        logic [32:0] sum;
        per   = (period_cfg == 0) ? 1 : period_cfg;
        // more than a byte's worth of valid bits clamps to eight
        nbits = (nv > 8) ? 8 : nv;
        for (i = 0; i < nbits; i++)
        begin
            bit_val = b[7 - i];
            if (bit_val == open_level)
            begin
                // same level extends the open run, saturating at all ones
                sum      = {1'b0, open_dur} + per;
                open_dur = sum[32] ? '1 : sum[31:0];
            end
            else
            begin
                // level change closes the open run if there is one
                if (open_dur != 0)
                    expected_runs.insert(expected_runs.size(),
                                         run_t'{open_dur, open_level, 1'b0});
                open_level = bit_val;
                open_dur   = per;
            end
        end
        if (fe)
        begin
            // frame end flushes the open run, empty frames give nothing
            if (open_dur != 0)
                expected_runs.insert(expected_runs.size(),
                                     run_t'{open_dur, open_level, 1'b1});
            open_level = 1'b0;
            open_dur   = '0;
        end
    endtask

    // sample all channels at the falling edge before the edge they act on:
    // check the outgoing run first, then predict from the incoming byte
    always @(negedge clk)
    begin
        run_t want;
        in_beat  = rst_n && in_valid && in_ready;
        out_beat = rst_n && out_valid && out_ready;
        cfg_beat = rst_n && cfg_valid && cfg_ready;
        if (out_beat)
        begin
            if (expected_runs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected run: duration %0d level %0d last %0d",
                             run_duration, run_level, run_last);
            end
            else
            begin
                want = expected_runs.pop_front();
                if (run_duration !== want.dur || run_level !== want.level ||
                    run_last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("run differs: want dur %0d lvl %0d last %0d, got %0d %0d %0d",
                                 want.dur, want.level, want.last,
                                 run_duration, run_level, run_last);
                end
            end
        end
        if (in_beat)
            predict_runs(data_byte, bits_valid, frame_end);
        if (cfg_beat)
            period_cfg = cfg_data;
        // watchdog: any beat restarts the count
        if (!rst_n || in_beat || out_beat || cfg_beat)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d runs pending",
                     STALL_LIMIT, expected_runs.size());
            $display("bit_run_to_pulse_encoder: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off when asked
    initial
    begin : receiver
        int unsigned hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req != hold_seen)
            begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one byte, after a random gap, and return at the edge that takes it;
    // valid stays high so the next byte can follow without a bubble
    task automatic send_byte(input logic [7:0] b, input logic [3:0] nv, input logic fe);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        bits_valid <= nv;
        frame_end  <= fe;
        do @(posedge clk); while (!in_beat);
    endtask

    // stop offering, wait for every pending run, then let the block settle
    task automatic drain_runs();
        in_valid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // period changes only between frames with the block idle
    task automatic write_period(input logic [PER_W-1:0] value);
        drain_runs();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_beat);
        cfg_valid <= 1'b0;
    endtask

    // one frame: mostly solid or random full bytes closed by a frame end with
    // a possibly partial last byte; noisy frames use any bits_valid and
    // scattered frame ends, still closed at the end
    task automatic send_frame(ref int unsigned sent, input bit noisy);
        int unsigned n_bytes;
        int unsigned k;
        logic [7:0]  b;
        logic [3:0]  nv;
        logic        fe;
        n_bytes = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 8);
        for (k = 0; k < n_bytes; k++)
        begin
            case ($urandom_range(4))
                0:       b = 8'h00;
                1:       b = 8'hFF;
                2:       b = ($urandom_range(1)) ? 8'h55 : 8'hAA;
                default: b = 8'($urandom);
            endcase
            fe = (k == n_bytes - 1);
            if (noisy)
            begin
                nv = 4'($urandom_range(0, 15));
                fe = fe || ($urandom_range(4) == 0);
            end
            else if (fe && $urandom_range(2) == 0)
                nv = 4'($urandom_range(1, 8));
            else
                nv = 4'd8;
            send_byte(b, nv, fe);
            if (nv != 0 || fe)
                sent++;
        end
    endtask

    // leading bits after reset, period at its reset value
    task automatic test_reset_state();
        send_idle_pct = 21;
        recv_idle_pct = 51;
        // high run opened from the cleared state, closed by a low byte
        send_byte(8'hFF, 4'd8, 1'b0);
        send_byte(8'h00, 4'd8, 1'b1);
        // low run opened from the cleared state
        send_byte(8'h0F, 4'd8, 1'b1);
        drain_runs();
    endtask

    // bits_valid extremes, empty frame end, most runs from one byte
    task automatic test_byte_fields();
        // no valid bits and no frame end: nothing happens
        send_byte(8'hA5, 4'd0, 1'b0);
        // frame end with no open run
        send_byte(8'h3C, 4'd0, 1'b1);
        // one-bit high run carried into a byte that toggles every bit
        send_byte(8'h80, 4'd1, 1'b0);
        send_byte(8'h55, 4'd8, 1'b1);
        // bits_valid above eight
        send_byte(8'hF0, 4'd15, 1'b1);
        send_byte(8'h0F, 4'd9, 1'b1);
        // partial last byte and an open run flushed by an empty frame end
        send_byte(8'hC7, 4'd3, 1'b0);
        send_byte(8'hFF, 4'd0, 1'b1);
        send_byte(8'hC7, 4'd3, 1'b1);
        drain_runs();
    endtask

    // a zero period acts as one
    task automatic test_zero_period();
        write_period('0);
        send_byte(8'h1E, 4'd8, 1'b0);
        send_byte(8'hE1, 4'd6, 1'b1);
        drain_runs();
    endtask

    // largest period
    task automatic test_max_period();
        write_period('1);
        send_byte(8'hFF, 4'd8, 1'b0);
        send_byte(8'h81, 4'd8, 1'b1);
        drain_runs();
    endtask

    // receiver holds off while bytes rich in level changes keep coming,
    // so the output backs up into the input
    task automatic test_output_backpressure();
        int unsigned k;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_period(16'd3);
        hold_req = ~hold_req;
        for (k = 0; k < 30; k++)
            send_byte((k % 2) ? 8'h55 : 8'hAA, 4'd8, k == 29);
        drain_runs();
    endtask

    // random frames under one idle setting, period changed now and then
    task automatic test_random_frames(input int unsigned snd_pct, input int unsigned rcv_pct);
        int unsigned      sent;
        logic [PER_W-1:0] per;
        sent          = 0;
        send_idle_pct = snd_pct;
        recv_idle_pct = rcv_pct;
        while (sent < PHASE_ITEMS)
        begin
            if ($urandom_range(99) < 10)
            begin
                case ($urandom_range(4))
                    0:       per = '0;
                    1:       per = 16'd1;
                    2:       per = '1;
                    default: per = 16'($urandom);
                endcase
                write_period(per);
            end
            send_frame(sent, $urandom_range(99) < 15);
        end
        drain_runs();
    endtask

    initial
    begin : main
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        data_byte  = '0;
        bits_valid = '0;
        frame_end  = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_byte_fields();
        test_zero_period();
        test_max_period();
        test_output_backpressure();
        test_random_frames(21, 51);
        test_random_frames(51, 21);
        test_random_frames(0, 0);
        write_period(16'd1);

        if (mismatches == 0)
            $display("bit_run_to_pulse_encoder: match");
        else
            $display("bit_run_to_pulse_encoder: mismatch");
        $finish;
    end

endmodule

[files.f]
hdl/brpe_pkg.sv
hdl/brpe_lane.sv
hdl/brpe_merge.sv
hdl/bit_run_to_pulse_encoder.sv
dv/tb_bit_run_to_pulse_encoder.sv
